[rtl/rcfd_pkg.sv]
`timescale 1ns / 1ps
package rcfd_pkg;
	localparam int CHANNELS = 14;
	localparam int CH_W = 4;
	localparam int POS_W = 5;
	localparam logic [POS_W-1:0] SUM_POS = POS_W'(2 * CHANNELS + 2);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(2 * CHANNELS + 3);

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_CSUM = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [2:0] REG_LEN = 3'd0;
	localparam logic [2:0] REG_CMD = 3'd1;
	localparam logic [2:0] REG_MIN = 3'd2;
	localparam logic [2:0] REG_MAX = 3'd3;
	localparam logic [2:0] REG_MID = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic byte_load;   // consume rx byte in datapath
		logic norm_start;  // start divide for channel ch_sel
		logic [CH_W-1:0] ch_sel;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic frame_done;  // final byte accepted this cycle
		logic csum_bad;
		logic range_bad;
		logic norm_done;
	} sts_t;
endpackage

[rtl/rcfd_datapath.sv]
`timescale 1ns / 1ps
module rcfd_datapath (
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] rx_byte,
	input  rcfd_pkg::cmd_t cmd,
	input  logic [7:0] len_byte,
	input  logic [7:0] cmd_byte,
	input  logic [15:0] ch_min,
	input  logic [15:0] ch_max,
	input  logic [15:0] ch_mid,
	output rcfd_pkg::sts_t sts,
	output logic [15:0] raw_q,
	output logic [15:0] norm_q,
	output logic [15:0] csum_q
);
	logic [rcfd_pkg::POS_W-1:0] pos_q;
	logic [7:0] low_q;
	logic fault_q;
	logic [15:0] store_q [rcfd_pkg::CHANNELS];
	logic [rcfd_pkg::CH_W-1:0] wr_ch;
	logic [15:0] word;

	// divider
	logic busy_q;
	logic neg_q;
	logic sat_q;
	logic zero_q;
	logic [4:0] cnt_q;
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [16:0] den_q;
	logic [16:0] num_s;
	logic [16:0] den_s;
	logic [16:0] num_abs;
	logic [16:0] den_abs;
	logic [32:0] trial;
	logic [31:0] q_final;

	assign wr_ch = rcfd_pkg::CH_W'((pos_q - rcfd_pkg::POS_W'(3)) >> 1);
	assign word = {rx_byte, low_q};
	assign num_s = {1'b0, raw_q} - {1'b0, ch_mid};
	assign den_s = {1'b0, ch_max} - {1'b0, ch_mid};
	assign num_abs = num_s[16] ? 17'(-num_s) : num_s;
	assign den_abs = den_s[16] ? 17'(-den_s) : den_s;
	assign trial = {rem_q[31:0], quo_q[31]} - {16'd0, den_q};

	always_comb begin
		sts.frame_done = cmd.byte_load && pos_q == rcfd_pkg::LAST_POS;
		sts.csum_bad = word != csum_q;
		sts.range_bad = fault_q;
		sts.norm_done = busy_q && cnt_q == 5'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			csum_q <= 16'hFFFF;
			low_q <= '0;
			fault_q <= 1'b0;
		end else if (cmd.byte_load) begin
			unique case (pos_q)
				5'd0: begin
					if (rx_byte == len_byte) begin
						csum_q <= 16'hFFFF - {8'd0, rx_byte};
						fault_q <= 1'b0;
						pos_q <= 5'd1;
					end
				end
				5'd1: begin
					if (rx_byte == cmd_byte) begin
						csum_q <= csum_q - {8'd0, rx_byte};
						pos_q <= 5'd2;
					end else if (rx_byte == len_byte) begin
						csum_q <= 16'hFFFF - {8'd0, rx_byte};
					end else begin
						pos_q <= 5'd0;
					end
				end
				rcfd_pkg::SUM_POS: begin
					low_q <= rx_byte;
					pos_q <= pos_q + 5'd1;
				end
				rcfd_pkg::LAST_POS: pos_q <= 5'd0;
				default: begin
					csum_q <= csum_q - {8'd0, rx_byte};
					if (!pos_q[0]) begin
						low_q <= rx_byte;
					end else if (word < ch_min || word > ch_max) begin
						fault_q <= 1'b1;
					end
					pos_q <= pos_q + 5'd1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.byte_load && pos_q > 5'd1 && pos_q < rcfd_pkg::SUM_POS && pos_q[0])
			store_q[wr_ch] <= word;
		if (cmd.norm_start)
			raw_q <= store_q[cmd.ch_sel];
	end

	// restoring divide, one quotient bit a cycle; starts in the cycle after the raw_q load
	logic start_d_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_d_q <= 1'b0;
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			start_d_q <= cmd.norm_start;
			if (start_d_q) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd31;
			end else if (busy_q) begin
				if (cnt_q == 5'd0)
					busy_q <= 1'b0;
				else
					cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_d_q) begin
			neg_q <= num_s[16] != den_s[16];
			zero_q <= num_s == 17'd0;
			sat_q <= den_s == 17'd0;
			den_q <= den_abs;
			rem_q <= '0;
			quo_q <= {num_abs[16:0], 15'd0};
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign q_final = !trial[32] ? {quo_q[30:0], 1'b1} : {quo_q[30:0], 1'b0};

	always_ff @(posedge clk) begin
		if (sts.norm_done) begin
			if (sat_q)
				norm_q <= zero_q ? 16'd0 : (neg_q ? 16'h8000 : 16'h7FFF);
			else if (neg_q)
				norm_q <= q_final >= 32'd32768 ? 16'h8000 : 16'(-q_final[15:0]);
			else
				norm_q <= q_final >= 32'd32767 ? 16'h7FFF : q_final[15:0];
		end
	end
endmodule

[rtl/rcfd_ctrl.sv]
`timescale 1ns / 1ps
module rcfd_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  rcfd_pkg::sts_t sts,
	output rcfd_pkg::cmd_t cmd,
	output logic [1:0] status_q,
	output logic [3:0] index_q,
	output logic last_q
);
	localparam logic [2:0] S_RX = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_DIV = 3'd2;
	localparam logic [2:0] S_OUT = 3'd3;
	localparam logic [2:0] S_ERR = 3'd4;

	logic [2:0] state_q;
	logic [rcfd_pkg::CH_W-1:0] ch_q;

	assign in_ready = state_q == S_RX;
	assign out_valid = state_q == S_OUT || state_q == S_ERR;
	assign cmd.byte_load = in_valid && in_ready;
	assign cmd.norm_start = state_q == S_START;
	assign cmd.ch_sel = ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RX;
			ch_q <= '0;
			status_q <= rcfd_pkg::ST_OK;
			index_q <= '0;
			last_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_RX: begin
					if (sts.frame_done) begin
						ch_q <= '0;
						index_q <= '0;
						last_q <= 1'b1;
						if (sts.csum_bad) begin
							status_q <= rcfd_pkg::ST_CSUM;
							state_q <= S_ERR;
						end else if (sts.range_bad) begin
							status_q <= rcfd_pkg::ST_RANGE;
							state_q <= S_ERR;
						end else begin
							status_q <= rcfd_pkg::ST_OK;
							state_q <= S_START;
						end
					end
				end
				S_START: state_q <= S_DIV;
				S_DIV: begin
					if (sts.norm_done) begin
						index_q <= ch_q;
						last_q <= ch_q == rcfd_pkg::CH_W'(rcfd_pkg::CHANNELS - 1);
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						if (last_q) begin
							state_q <= S_RX;
						end else begin
							ch_q <= ch_q + rcfd_pkg::CH_W'(1);
							state_q <= S_START;
						end
					end
				end
				S_ERR: if (out_ready) state_q <= S_RX;
				default: state_q <= S_RX;
			endcase
		end
	end
endmodule

[rtl/rc_serial_frame_sync_decoder_top.sv]
`timescale 1ns / 1ps
// channel   dir  payload
// s_axis    in   tdata[7:0] = rx_byte
// m_axis    out  tdata = status, channel_index, raw_value, normalized_value, computed_checksum
// cfg       in   cfg_we, cfg_index, cfg_data
// one byte request per cycle while hunting or collecting a frame
// a good frame gives 14 results, one channel at a time: each raw value is loaded, put through
// the 32-step restoring divider and handed off, and the next channel starts only once it is taken
// error frames give one result; input stalls until results are taken
// arst_n clears position, checksum and registers to their defaults
module rc_serial_frame_sync_decoder_top (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // rx_byte
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// status[1:0], channel_index[5:2], raw_value[21:6], normalized_value[37:22],
	// computed_checksum[53:38], zero fill
	output logic [55:0] m_axis_tdata,
	output logic m_axis_tlast,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data
);
	logic [7:0] len_q;
	logic [7:0] cmdb_q;
	logic [15:0] min_q;
	logic [15:0] max_q;
	logic [15:0] mid_q;
	rcfd_pkg::cmd_t cmd;
	rcfd_pkg::sts_t sts;
	logic [15:0] raw;
	logic [15:0] norm;
	logic [15:0] csum;
	logic [1:0] status;
	logic [3:0] index;
	logic ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= 8'd32;
			cmdb_q <= 8'd64;
			min_q <= 16'd1000;
			max_q <= 16'd2000;
			mid_q <= 16'd1500;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rcfd_pkg::REG_LEN: len_q <= cfg_data[7:0];
				rcfd_pkg::REG_CMD: cmdb_q <= cfg_data[7:0];
				rcfd_pkg::REG_MIN: min_q <= cfg_data;
				rcfd_pkg::REG_MAX: max_q <= cfg_data;
				rcfd_pkg::REG_MID: mid_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rcfd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.sts(sts), .cmd(cmd),
		.status_q(status), .index_q(index), .last_q(m_axis_tlast)
	);

	rcfd_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .rx_byte(s_axis_tdata), .cmd(cmd),
		.len_byte(len_q), .cmd_byte(cmdb_q),
		.ch_min(min_q), .ch_max(max_q), .ch_mid(mid_q),
		.sts(sts), .raw_q(raw), .norm_q(norm), .csum_q(csum)
	);

	assign ok = status == rcfd_pkg::ST_OK;
	assign m_axis_tdata = {2'b00, csum, ok ? norm : 16'd0, ok ? raw : 16'd0, index, status};
endmodule

[rtl/rcfd_checker.sv]
`timescale 1ns / 1ps
module rcfd_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic m_axis_tlast
);
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] != rcfd_pkg::ST_OK |-> m_axis_tlast)
		else $error("error result without last");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");
endmodule

bind rc_serial_frame_sync_decoder_top rcfd_checker u_chk (.*);
